@@ sv/nnsp_pkg.sv @@
// Constants and lookup functions shared by the note name stream parser.
package nnsp_pkg;

    localparam int unsigned MAX_NOTES_DEFAULT = 256;

    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned TRANSPOSE_W = 6;
    localparam int unsigned FREQ_W      = 23;
    localparam int unsigned LED_W       = 5;
    localparam int unsigned MIDI_W      = 8;
    localparam int unsigned INDEX_W     = 8;
    localparam int unsigned PITCH_W     = 26;
    localparam int unsigned S_TDATA_W   = 8;
    localparam int unsigned M_TDATA_W   = 48;

    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_A       = 8'h61;
    localparam logic [CHAR_W-1:0] CH_C       = 8'h63;
    localparam logic [CHAR_W-1:0] CH_G       = 8'h67;
    localparam logic [CHAR_W-1:0] CH_H       = 8'h68;
    localparam logic [CHAR_W-1:0] CH_SHARP   = 8'h23;
    localparam logic [CHAR_W-1:0] CH_COMMA   = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_DOT     = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ONE     = 8'h31;
    localparam logic [CHAR_W-1:0] CH_SEVEN   = 8'h37;

    localparam logic [2:0]        OCTAVE_RESET = 3'd3;
    localparam logic [FREQ_W-1:0] FREQ_MAX     = 23'h7FFFFF;
    localparam logic [LED_W-1:0]  LED_NONE     = 5'h1F;

    // Semitones above A for letters a..h (h is b)
    function automatic logic [3:0] semis_from_a(input logic [2:0] idx);
        logic [3:0] s;
        case (idx)
            3'd0:    s = 4'd0;
            3'd1:    s = 4'd2;
            3'd2:    s = 4'd3;
            3'd3:    s = 4'd5;
            3'd4:    s = 4'd7;
            3'd5:    s = 4'd8;
            3'd6:    s = 4'd10;
            3'd7:    s = 4'd2;
            default: s = 4'd0;
        endcase
        return s;
    endfunction

    // 440 Hz * 2^(r/12) in Q16
    function automatic logic [PITCH_W-1:0] pitch_q16(input logic [3:0] r);
        logic [PITCH_W-1:0] p;
        case (r)
            4'd0:    p = 26'd28835840;
            4'd1:    p = 26'd30550508;
            4'd2:    p = 26'd32367136;
            4'd3:    p = 26'd34291786;
            4'd4:    p = 26'd36330882;
            4'd5:    p = 26'd38491228;
            4'd6:    p = 26'd40780036;
            4'd7:    p = 26'd43204943;
            4'd8:    p = 26'd45774043;
            4'd9:    p = 26'd48495909;
            4'd10:   p = 26'd51379626;
            4'd11:   p = 26'd54434817;
            default: p = 26'd0;
        endcase
        return p;
    endfunction

    // LED code per class index 1..13; index 0 means none
    function automatic logic [LED_W-1:0] led_of_class(input logic [3:0] idx);
        logic [LED_W-1:0] l;
        case (idx)
            4'd1:    l = 5'd0;
            4'd2:    l = 5'd10;
            4'd3:    l = 5'd1;
            4'd4:    l = 5'd11;
            4'd5:    l = 5'd2;
            4'd6:    l = 5'd3;
            4'd7:    l = 5'd12;
            4'd8:    l = 5'd4;
            4'd9:    l = 5'd13;
            4'd10:   l = 5'd5;
            4'd11:   l = 5'd14;
            4'd12:   l = 5'd6;
            4'd13:   l = 5'd7;
            default: l = LED_NONE;
        endcase
        return l;
    endfunction

endpackage

@@ sv/note_name_stream_parser_core.sv @@
// Note name stream parser: note text characters in, note and pause records out.
//
// Usage: characters arrive on the s_ channel, one per transfer, with s_tlast on
// the last character of a text. Each note (letter, optional '#', optional octave
// char) or '.' pause yields one record on the m_ channel; m_tuser flags a pause.
// The user must write the transpose register over cfg_valid/cfg_ready/cfg_data
// only while no character is in flight; the block itself does not enforce this.
// cfg_ready is always high. A character is registered in the input register on
// accept and decoded and priced combinationally from it; its record is loaded
// into the output register, which drives m_tvalid, when the character advances.
// Throughput: one character per cycle unless the output stalls, set by the
// single decode-and-price path between the input and output registers.
// Reset (aresetn low, synchronous) empties both registers, returns the octave
// to 3 and the note count and transpose to zero.
// When m_tready is low the finished record holds; characters that give no
// record keep passing, and the input stalls once a record-making character
// waits behind it.
module note_name_stream_parser_core #(
    parameter int unsigned MAX_NOTES = nnsp_pkg::MAX_NOTES_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [nnsp_pkg::TRANSPOSE_W-1:0]    cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [nnsp_pkg::S_TDATA_W-1:0]      s_tdata,   // [7:0] char_code
    input  logic                                s_tlast,   // final_char
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [7:0] note_index, [30:8] frequency, [35:31] led_code, [43:36] midi_number,
    // [47:44] zero
    output logic [nnsp_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tuser    // [0] is_pause
);
    import nnsp_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_NOTES);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_NOTES - 1);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LETTER,
        PH_SHARP,
        PH_AFTER
    } phase_t;

    // Registers
    phase_t                    phase_reg, phase_next;
    logic [3:0]                halftones_reg, halftones_next;
    logic                      c_above_reg, c_above_next;
    logic [2:0]                octave_reg, octave_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [TRANSPOSE_W-1:0]    transpose_reg;
    logic                      in_valid_reg;
    logic [CHAR_W-1:0]         in_char_reg;
    logic                      in_last_reg;
    logic                      out_valid_reg;
    logic [INDEX_W-1:0]        out_index_reg;
    logic                      out_pause_reg;
    logic [FREQ_W-1:0]         out_freq_reg;
    logic [LED_W-1:0]          out_led_reg;
    logic [MIDI_W-1:0]         out_midi_reg;

    // Decode
    logic [CHAR_W-1:0]  ch;
    phase_t             eff_phase;
    logic               comma_eaten;
    logic               in_note;
    logic               sharp_step;
    logic               note_done;
    logic               letter_start;
    logic               pause_emit;
    logic [2:0]         octave_upd;
    logic               tail_emit;
    logic               note_emit;
    logic               any_emit;
    logic               advance;

    // Pricing
    logic [3:0]         em_semis;
    logic               em_c_above;
    logic [2:0]         oct_base;
    logic [6:0]         oct12;
    logic signed [9:0]  u_wide;
    logic [7:0]         u8;
    logic [15:0]        prod;
    logic [4:0]         q;
    logic [7:0]         q12;
    logic [3:0]         r;
    logic [4:0]         n;
    logic [PITCH_W:0]   sum;
    logic [PITCH_W:0]   shifted;
    logic [FREQ_W-1:0]  freq;
    logic [3:0]         led_idx;
    logic [MIDI_W-1:0]  midi;

    always_comb begin
        ch = in_char_reg;
        if (in_char_reg >= CH_UPPER_A && in_char_reg <= CH_UPPER_Z) begin
            ch = in_char_reg + 8'h20;
        end

        eff_phase   = (phase_reg == PH_AFTER) ? PH_IDLE : phase_reg;
        comma_eaten = (phase_reg == PH_AFTER) && (ch == CH_COMMA);
        in_note     = (eff_phase == PH_LETTER) || (eff_phase == PH_SHARP);
        sharp_step  = (eff_phase == PH_LETTER) && (ch == CH_SHARP);
        note_done   = in_note && !sharp_step;
        letter_start = (eff_phase == PH_IDLE) && !comma_eaten && ch >= CH_A && ch <= CH_H;
        pause_emit  = (eff_phase == PH_IDLE) && !comma_eaten && (ch == CH_DOT);

        octave_upd = octave_reg;
        if (note_done && ch >= CH_ONE && ch <= CH_SEVEN) begin
            octave_upd = ch[2:0];
        end

        halftones_next = halftones_reg;
        c_above_next   = c_above_reg;
        phase_next     = eff_phase;
        if (sharp_step) begin
            halftones_next = halftones_reg + 4'd1;
            phase_next     = PH_SHARP;
        end else if (note_done) begin
            phase_next = PH_AFTER;
        end else if (letter_start) begin
            halftones_next = semis_from_a(3'(ch - CH_A));
            c_above_next   = (ch >= CH_C) && (ch <= CH_G);
            phase_next     = PH_LETTER;
        end

        // text ending while a note waits for its octave character
        tail_emit = in_last_reg && !note_done && !pause_emit &&
                    ((phase_next == PH_LETTER) || (phase_next == PH_SHARP));
        note_emit = note_done || tail_emit;
        any_emit  = note_emit || pause_emit;

        count_next  = count_reg;
        octave_next = octave_upd;
        if (any_emit) begin
            count_next = (count_reg == CNT_LAST) ? '0 : count_reg + 1'b1;
        end
        if (in_last_reg) begin
            phase_next  = PH_IDLE;
            octave_next = OCTAVE_RESET;
            count_next  = '0;
        end

        advance  = in_valid_reg && (!any_emit || !out_valid_reg || m_tready);
        s_tready = !in_valid_reg || advance;
    end

    // Frequency, LED and MIDI for the note being emitted
    always_comb begin
        em_semis   = tail_emit ? halftones_next : halftones_reg;
        em_c_above = tail_emit ? c_above_next : c_above_reg;
        oct_base   = octave_upd - {2'b00, em_c_above};
        oct12      = {1'b0, oct_base, 3'b000} + {2'b00, oct_base, 2'b00};
        // u = midi + 51, always 40..198 here
        u_wide = $signed({3'b000, oct12}) + $signed({6'b000000, em_semis}) + 10'sd72
                 + $signed({{(10 - TRANSPOSE_W){transpose_reg[TRANSPOSE_W-1]}},
                            transpose_reg});
        u8   = u_wide[7:0];
        midi = MIDI_W'(u_wide - 10'sd51);
        // u / 12 by reciprocal, exact over 0..255
        prod = {8'h00, u8} * 16'd171;
        q    = prod[15:11];
        q12  = {q, 3'b000} + {1'b0, q, 2'b00};
        r    = 4'(u8 - q12);
        n    = 5'd18 - q;
        sum  = {1'b0, pitch_q16(r)} + ((PITCH_W+1)'(1) << (n - 5'd1));
        shifted = sum >> n;
        freq = (|shifted[PITCH_W:FREQ_W]) ? FREQ_MAX : shifted[FREQ_W-1:0];
        led_idx = (r >= 4'd3) ? (r - 4'd2) : (r + 4'd10);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            halftones_reg <= '0;
            c_above_reg   <= 1'b0;
            octave_reg    <= OCTAVE_RESET;
            count_reg     <= '0;
            transpose_reg <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                transpose_reg <= cfg_data;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                phase_reg     <= phase_next;
                halftones_reg <= halftones_next;
                c_above_reg   <= c_above_next;
                octave_reg    <= octave_next;
                count_reg     <= count_next;
            end
            if (advance && any_emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (s_tready && s_tvalid) begin
            in_char_reg <= s_tdata[CHAR_W-1:0];
            in_last_reg <= s_tlast;
        end
        if (advance && any_emit) begin
            out_index_reg <= INDEX_W'(count_reg);
            out_pause_reg <= pause_emit;
            if (pause_emit) begin
                out_freq_reg <= '0;
                out_led_reg  <= LED_NONE;
                out_midi_reg <= '0;
            end else begin
                out_freq_reg <= freq;
                out_led_reg  <= led_of_class(led_idx);
                out_midi_reg <= midi;
            end
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tuser   = out_pause_reg;
    assign m_tdata   = {4'b0000, out_midi_reg, out_led_reg, out_freq_reg, out_index_reg};

endmodule
